/* sv/wirf_pkg.sv */
// Shared constants, types and helpers of the window island-removal filter.
`timescale 1ns / 1ps
`default_nettype none
package wirf_pkg;

	// Window geometry and frame limits
	localparam int WIN_SIZE    = 5;
	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int KOFF        = (WIN_SIZE - 1) / 2;
	localparam int KAREA       = WIN_SIZE * WIN_SIZE;
	localparam int CENTER_IDX  = KOFF * WIN_SIZE + KOFF;
	localparam int LB_ROWS     = WIN_SIZE - 1;

	// Register fields and reset values
	localparam int DIM_W      = 12;
	localparam int LIMIT_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_LIMIT  = 4;

	// Internal widths
	localparam int COLOR_W    = 24;
	localparam int WE_W       = $clog2(MAX_WIDTH + 1);
	localparam int HE_W       = $clog2(MAX_HEIGHT + 1);
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int CMEM_AW    = $clog2(KOFF * MAX_WIDTH + KOFF + 2);
	localparam int CMEM_DEPTH = 2 ** CMEM_AW;
	localparam int VCNT_W     = $clog2(KAREA + 1);
	localparam int VIDX_W     = $clog2(KAREA);

	// Result queue
	localparam int QDEPTH = 16;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int CRED_W = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_ISLAND_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef logic [COLOR_W-1:0] color_t;
	typedef color_t [LB_ROWS-1:0] lb_col_t;
	typedef color_t [KAREA-1:0] window_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] in_blue;
		logic [7:0] in_green;
		logic [7:0] in_red;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       was_replaced;
		logic       frame_last;
	} out_item_t;

	// Classified output position handed from front to vote pipeline
	typedef struct packed {
		logic   valid;
		logic   border;
		logic   last;
		color_t center;
	} job_t;

	function automatic logic [WE_W-1:0] eff_width(input logic [DIM_W-1:0] v);
		logic [WE_W-1:0] r;
		if (v == '0) r = WE_W'(1);
		else if (int'(v) > MAX_WIDTH) r = WE_W'(MAX_WIDTH);
		else r = WE_W'(v);
		return r;
	endfunction

	function automatic logic [HE_W-1:0] eff_height(input logic [DIM_W-1:0] v);
		logic [HE_W-1:0] r;
		if (v == '0) r = HE_W'(1);
		else if (int'(v) > MAX_HEIGHT) r = HE_W'(MAX_HEIGHT);
		else r = HE_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/wirf_ram.sv */
// Generic simple dual-port RAM with registered read (old data on collision).
`timescale 1ns / 1ps
`default_nettype none
module wirf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/wirf_front.sv */
// Front end: accept, frame counters, line stores, window and classification.
`timescale 1ns / 1ps
`default_nettype none
module wirf_front import wirf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire in_item_t              sample,
	output logic                       full,
	input  wire logic                  pop_xfer,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic [LIMIT_W-1:0]         limit,
	output job_t                       job,
	output window_t                    window
);
	logic [WE_W-1:0]    w_q;
	logic [HE_W-1:0]    h_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   total_q, lag_q;
	logic [CNT_W-1:0]   accepted_q, emitted_q;
	logic [X_W-1:0]     in_x_q, out_x_q;
	logic [Y_W-1:0]     out_y_q;
	logic [CRED_W-1:0]  cred_q;

	logic             acc, pix_ok, pix_emit, fl_emit, emit, border, last, geom_wr;
	logic             in_wrap, out_wrap;
	logic [WE_W-1:0]  wn;
	logic [HE_W-1:0]  hn;
	logic [CNT_W-1:0] pend;
	color_t           pixel;

	logic             pix_v_s1, fwd_s1, emit_s1, border_s1, last_s1;
	logic [X_W-1:0]   x_s1;
	color_t           pix_s1;
	lb_col_t          fwd_col_s1, col_old, lb_rcol, lb_wcol;
	logic [COLOR_W*LB_ROWS-1:0] lb_rdata;
	color_t           center_rd;
	window_t          window_q;
	logic             valid_s2, border_s2, last_s2;
	color_t           center_s2;

	assign wn      = eff_width(cfg_data);
	assign hn      = eff_height(cfg_data);
	assign geom_wr = cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT);
	assign pixel   = {sample.in_red, sample.in_green, sample.in_blue};

	// Classify the transfer and the output position it releases
	always_comb begin
		acc      = push && !full;
		pend     = accepted_q - emitted_q;
		pix_ok   = acc && sample.opcode == OP_PIXEL && accepted_q < total_q;
		pix_emit = pix_ok && pend >= lag_q;
		fl_emit  = acc && sample.opcode == OP_FLUSH && accepted_q == total_q &&
			emitted_q < accepted_q;
		emit     = pix_emit || fl_emit;
		border   = (out_y_q < Y_W'(KOFF)) || (out_x_q < X_W'(KOFF)) ||
			((HE_W + 1)'(out_y_q) + (HE_W + 1)'(KOFF) >= (HE_W + 1)'(h_q)) ||
			((WE_W + 1)'(out_x_q) + (WE_W + 1)'(KOFF) >= (WE_W + 1)'(w_q));
		last     = (emitted_q + CNT_W'(1)) == total_q;
		in_wrap  = (WE_W'(in_x_q) + WE_W'(1)) == w_q;
		out_wrap = (WE_W'(out_x_q) + WE_W'(1)) == w_q;
	end

	// Hold the configuration and derived frame size and lag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= WE_W'(RST_WIDTH);
			h_q     <= HE_W'(RST_HEIGHT);
			limit_q <= LIMIT_W'(RST_LIMIT);
			total_q <= CNT_W'(RST_WIDTH * RST_HEIGHT);
			lag_q   <= CNT_W'(KOFF * RST_WIDTH + KOFF);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRAME_WIDTH: begin
					w_q     <= wn;
					total_q <= CNT_W'(wn) * CNT_W'(h_q);
					lag_q   <= CNT_W'(KOFF) * CNT_W'(wn) + CNT_W'(KOFF);
				end
				REG_FRAME_HEIGHT: begin
					h_q     <= hn;
					total_q <= CNT_W'(w_q) * CNT_W'(hn);
				end
				REG_ISLAND_LIMIT: begin
					limit_q <= cfg_data[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the frame counters; restart on frame end or geometry write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= '0;
			emitted_q  <= '0;
			in_x_q     <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
		end else if (geom_wr) begin
			accepted_q <= '0;
			emitted_q  <= '0;
			in_x_q     <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
		end else begin
			if (pix_ok) begin
				accepted_q <= accepted_q + CNT_W'(1);
				in_x_q     <= in_wrap ? '0 : in_x_q + X_W'(1);
			end
			if (emit) begin
				if (last) begin
					accepted_q <= '0;
					emitted_q  <= '0;
					in_x_q     <= '0;
					out_x_q    <= '0;
					out_y_q    <= '0;
				end else begin
					emitted_q <= emitted_q + CNT_W'(1);
					if (out_wrap) begin
						out_x_q <= '0;
						out_y_q <= out_y_q + Y_W'(1);
					end else begin
						out_x_q <= out_x_q + X_W'(1);
					end
				end
			end
		end
	end

	// Reserve a result queue slot per released position; free it on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			cred_q <= cred_q + CRED_W'(acc && emit) - CRED_W'(pop_xfer);
		end
	end
	assign full = cred_q == CRED_W'(QDEPTH);

	// Center store: pixels wait here until their output position is released
	wirf_ram #(.WIDTH(COLOR_W), .DEPTH(CMEM_DEPTH)) u_cmem (
		.clk   (clk),
		.we    (pix_ok),
		.waddr (accepted_q[CMEM_AW-1:0]),
		.wdata (pixel),
		.raddr (emitted_q[CMEM_AW-1:0]),
		.rdata (center_rd)
	);

	// Line stores: one word per column holds the previous rows
	wirf_ram #(.WIDTH(COLOR_W * LB_ROWS), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (pix_v_s1),
		.waddr (x_s1),
		.wdata (lb_wcol),
		.raddr (in_x_q),
		.rdata (lb_rdata)
	);

	assign lb_rcol = lb_col_t'(lb_rdata);
	assign col_old = fwd_s1 ? fwd_col_s1 : lb_rcol;

	// Push the new pixel into the column, dropping the oldest row
	always_comb begin
		lb_wcol[0] = pix_s1;
		for (int k = 1; k < LB_ROWS; k++) begin
			lb_wcol[k] = col_old[k-1];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_v_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			pix_v_s1 <= pix_ok;
			emit_s1  <= acc && emit;
		end
	end

	// Stage 1 payload; forward a column written in the same cycle it is read
	always_ff @(posedge clk) begin
		if (pix_ok) begin
			x_s1       <= in_x_q;
			pix_s1     <= pixel;
			fwd_s1     <= pix_v_s1 && x_s1 == in_x_q;
			fwd_col_s1 <= lb_wcol;
		end
		border_s1 <= border;
		last_s1   <= last;
	end

	// Shift the window one column left and load the new column on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (pix_v_s1) begin
			for (int r = 0; r < WIN_SIZE; r++) begin
				for (int c = 0; c < WIN_SIZE - 1; c++) begin
					window_q[r*WIN_SIZE+c] <= window_q[r*WIN_SIZE+c+1];
				end
				if (r == WIN_SIZE - 1) begin
					window_q[r*WIN_SIZE+WIN_SIZE-1] <= pix_s1;
				end else begin
					window_q[r*WIN_SIZE+WIN_SIZE-1] <= col_old[WIN_SIZE-2-r];
				end
			end
		end
	end

	// Stage 2: hand the job to the vote pipeline along with the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		border_s2 <= border_s1;
		last_s2   <= last_s1;
		center_s2 <= center_rd;
	end

	assign job    = '{valid: valid_s2, border: border_s2, last: last_s2, center: center_s2};
	assign window = window_q;
	assign limit  = limit_q;
endmodule
`default_nettype wire

/* sv/wirf_vote.sv */
// Back end: counts window colors and picks the dominant one.
`timescale 1ns / 1ps
`default_nettype none
module wirf_vote import wirf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire job_t               job,
	input  wire window_t            window,
	input  wire logic [LIMIT_W-1:0] limit,
	output logic                    res_valid,
	output out_item_t               res
);
	logic [KAREA-1:0][KAREA-1:0] eq_c, eq_v1;
	job_t    job_v1, job_v2, job_v3;
	window_t win_v1, win_v2, win_v3;
	logic [VCNT_W-1:0] cnt_v2 [KAREA];
	logic [VCNT_W-1:0] rcnt_c [WIN_SIZE];
	logic [VIDX_W-1:0] ridx_c [WIN_SIZE];
	logic [VCNT_W-1:0] rcnt_v3 [WIN_SIZE];
	logic [VIDX_W-1:0] ridx_v3 [WIN_SIZE];
	logic [VCNT_W-1:0] ccnt_v3, bcnt;
	logic [VIDX_W-1:0] bidx;
	color_t            best, color;
	logic              take;
	logic              valid_v1, valid_v2, valid_v3, valid_v4;
	out_item_t         res_v4;

	// Compare every pair of window pixels
	always_comb begin
		for (int i = 0; i < KAREA; i++) begin
			for (int j = 0; j < KAREA; j++) begin
				eq_c[i][j] = window[i] == window[j];
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_v1 <= 1'b0;
			valid_v2 <= 1'b0;
			valid_v3 <= 1'b0;
			valid_v4 <= 1'b0;
		end else begin
			valid_v1 <= job.valid;
			valid_v2 <= valid_v1;
			valid_v3 <= valid_v2;
			valid_v4 <= valid_v3;
		end
	end

	// Per row: the lowest index holding the highest count
	always_comb begin
		for (int r = 0; r < WIN_SIZE; r++) begin
			rcnt_c[r] = cnt_v2[r*WIN_SIZE];
			ridx_c[r] = VIDX_W'(r * WIN_SIZE);
			for (int c = 1; c < WIN_SIZE; c++) begin
				if (cnt_v2[r*WIN_SIZE+c] > rcnt_c[r]) begin
					rcnt_c[r] = cnt_v2[r*WIN_SIZE+c];
					ridx_c[r] = VIDX_W'(r * WIN_SIZE + c);
				end
			end
		end
	end

	// Stage payloads: match matrix, counts, row winners
	always_ff @(posedge clk) begin
		eq_v1  <= eq_c;
		win_v1 <= window;
		job_v1 <= job;

		for (int i = 0; i < KAREA; i++) begin
			cnt_v2[i] <= VCNT_W'($countones(eq_v1[i]));
		end
		win_v2 <= win_v1;
		job_v2 <= job_v1;

		for (int r = 0; r < WIN_SIZE; r++) begin
			rcnt_v3[r] <= rcnt_c[r];
			ridx_v3[r] <= ridx_c[r];
		end
		ccnt_v3 <= cnt_v2[CENTER_IDX];
		win_v3  <= win_v2;
		job_v3  <= job_v2;
	end

	// Across rows, then decide between center and dominant color
	always_comb begin
		bcnt = rcnt_v3[0];
		bidx = ridx_v3[0];
		for (int r = 1; r < WIN_SIZE; r++) begin
			if (rcnt_v3[r] > bcnt) begin
				bcnt = rcnt_v3[r];
				bidx = ridx_v3[r];
			end
		end
		best  = win_v3[bidx];
		take  = !job_v3.border && ((LIMIT_W + 1)'(ccnt_v3) <= (LIMIT_W + 1)'(limit));
		color = take ? best : job_v3.center;
	end

	always_ff @(posedge clk) begin
		res_v4.out_blue     <= color[7:0];
		res_v4.out_green    <= color[15:8];
		res_v4.out_red      <= color[23:16];
		res_v4.was_replaced <= take && best != job_v3.center;
		res_v4.frame_last   <= job_v3.last;
	end

	assign res_valid = valid_v4;
	assign res       = res_v4;
endmodule
`default_nettype wire

/* sv/wirf_queue.sv */
// Result queue between the vote pipeline and the output port.
`timescale 1ns / 1ps
`default_nettype none
module wirf_queue import wirf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr,
	input  wire out_item_t din,
	input  wire logic      rd,
	output logic           empty,
	output out_item_t      dout
);
	out_item_t         mem_q [QDEPTH];
	logic [QAW-1:0]    wptr_q, rptr_q;
	logic [CRED_W-1:0] cnt_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + QAW'(1);
			if (rd) rptr_q <= rptr_q + QAW'(1);
			cnt_q <= cnt_q + CRED_W'(wr) - CRED_W'(rd);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= din;
	end

	assign empty = cnt_q == '0;
	assign dout  = mem_q[rptr_q];
endmodule
`default_nettype wire

/* sv/window_island_removal_filter.sv */
// Top level of the window island-removal (mode) filter.
`timescale 1ns / 1ps
`default_nettype none
// Raster pixels enter at up to one per clock while full is low; flush items
// drain the last KOFF*width+KOFF outputs once the frame is in. Each result
// leaves the pipeline after the transfer that releases it, through line
// store read, window shift, pair compare, count and two argmax stages, and
// waits in a 16-entry result queue. full rises when 16 results are reserved
// and not yet popped, so with pop held high the block sustains one item per
// clock. Configuration takes effect on the next cycle; a width or height
// write restarts the frame. No clearing pass: there is no wait after reset.
module window_island_removal_filter import wirf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_item_t              sample,
	output logic                       empty,
	input  wire logic                  pop,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	logic               pop_xfer, res_valid;
	logic [LIMIT_W-1:0] limit;
	job_t               job;
	window_t            window;
	out_item_t          res;

	assign pop_xfer = pop && !empty;

	wirf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.pop_xfer (pop_xfer),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.limit    (limit),
		.job      (job),
		.window   (window)
	);

	wirf_vote u_vote (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.window    (window),
		.limit     (limit),
		.res_valid (res_valid),
		.res       (res)
	);

	wirf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_valid),
		.din    (res),
		.rd     (pop_xfer),
		.empty  (empty),
		.dout   (result)
	);
endmodule
`default_nettype wire

/* sv/wirf_checker.sv */
// Port-level checks of the filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module wirf_checker import wirf_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  full,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire out_item_t             result,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_idx
);
	logic [VCNT_W-1:0] since_q;
	logic              out_xfer;

	assign out_xfer = pop && !empty;

	// Count result transfers since the frame started, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q <= '0;
		end else if (cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT)) begin
			since_q <= '0;
		end else if (out_xfer) begin
			if (result.frame_last) since_q <= '0;
			else if (since_q < VCNT_W'(KOFF)) since_q <= since_q + VCNT_W'(1);
		end
	end

	// A waiting result holds until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	// The last pixel of a frame is on the right edge and is never replaced
	a_last_edge: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.frame_last |-> !result.was_replaced)
		else $error("frame_last pixel replaced");

	// The first pixels of a frame lie on the top edge and pass unchanged
	a_top_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && since_q < VCNT_W'(KOFF) |-> !result.was_replaced)
		else $error("top edge pixel replaced");

	// Reserved slots are only released by a result transfer
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		full && !out_xfer |=> full)
		else $error("full dropped without a result transfer");
endmodule

bind window_island_removal_filter wirf_checker u_wirf_checker (.*);
`default_nettype wire
